// File: sv/pdpm_pkg.sv
// Shared types and constants of the PWM duty and period meter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package pdpm_pkg;

    // Field widths fixed by the item formats
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = 25;
    localparam int CLK_W    = 27;
    localparam int DUTY_W   = 15;

    // Parameter defaults
    localparam int STAMP_BITS_DEF = 24;
    localparam int INTERVALS_DEF  = 2;

    localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [DUTY_W-1:0] DUTY_FULL   = 15'd25600;
    localparam logic [CLK_W-1:0]  CLOCK_RESET = 27'd120000000;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EDGE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MEASURED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TO_HIGH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TO_LOW   = 2'd2;

    // One pending result, handed from the front end to the divider
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SUM_W-1:0]    high_ticks;
        logic [SUM_W-1:0]    low_ticks;
        logic [SUM_W-1:0]    period_ticks;
    } t_job;

endpackage

// File: sv/pdpm_ifs.sv
// Request and result channel interfaces of the PWM duty and period meter.
// Depends on pdpm_pkg for the field widths.
`timescale 1ns / 1ps

interface pdpm_req_if #(
    parameter int STAMP_BITS = pdpm_pkg::STAMP_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [pdpm_pkg::REQ_W-1:0]  req_type;
    logic [STAMP_BITS-1:0]       stamp;
    logic                        pin_level;

    modport source (output valid, req_type, stamp, pin_level, input ready);
    modport sink   (input valid, req_type, stamp, pin_level, output ready);
endinterface

interface pdpm_res_if;
    logic                           valid;
    logic                           ready;
    logic [pdpm_pkg::STATUS_W-1:0]  status;
    logic [pdpm_pkg::SUM_W-1:0]     high_ticks;
    logic [pdpm_pkg::SUM_W-1:0]     low_ticks;
    logic [pdpm_pkg::SUM_W-1:0]     period_ticks;
    logic [pdpm_pkg::CLK_W-1:0]     freq_hz;
    logic [pdpm_pkg::DUTY_W-1:0]    duty_pct_q8;

    modport source (output valid, status, high_ticks, low_ticks, period_ticks,
                    freq_hz, duty_pct_q8, input ready);
    modport sink   (input valid, status, high_ticks, low_ticks, period_ticks,
                    freq_hz, duty_pct_q8, output ready);
endinterface

// File: sv/pdpm_front.sv
// Front end: accepts requests, tracks level, reference and the tick sums,
// and pushes a job for every finished measurement or timeout. Uses pdpm_pkg.
`timescale 1ns / 1ps

module pdpm_front #(
    parameter int STAMP_BITS = pdpm_pkg::STAMP_BITS_DEF,
    parameter int INTERVALS  = pdpm_pkg::INTERVALS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pdpm_req_if.sink              i_req,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output pdpm_pkg::t_job        o_push_data
);
    localparam int SUM_W = pdpm_pkg::SUM_W;
    localparam int ADD_W = ((STAMP_BITS > SUM_W) ? STAMP_BITS : SUM_W) + 1;
    localparam int CNT_W = $clog2(INTERVALS + 1);

    logic                  r_measuring, n_measuring;
    logic                  r_have_ref, n_have_ref;
    logic                  r_level, n_level;
    logic [STAMP_BITS-1:0] r_last, n_last;
    logic [SUM_W-1:0]      r_high, n_high;
    logic [SUM_W-1:0]      r_low, n_low;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic                  w_accept;
    logic [STAMP_BITS-1:0] w_delta;
    logic [ADD_W-1:0]      w_acc_in;
    logic [ADD_W-1:0]      w_acc_sum;
    logic [SUM_W-1:0]      w_acc_sat;
    logic [SUM_W:0]        w_per_sum;
    logic [SUM_W-1:0]      w_per_sat;
    logic [CNT_W-1:0]      w_cnt_inc;

    assign i_req.ready = i_push_ready;
    assign w_accept    = i_req.valid && i_push_ready;

    assign w_delta   = i_req.stamp - r_last;
    // saturating add of the interval into the sum chosen by the level
    assign w_acc_in  = r_level ? ADD_W'(r_high) : ADD_W'(r_low);
    assign w_acc_sum = w_acc_in + ADD_W'(w_delta);
    assign w_acc_sat = (w_acc_sum > ADD_W'(pdpm_pkg::SUM_MAX)) ?
                       pdpm_pkg::SUM_MAX : w_acc_sum[SUM_W-1:0];
    assign w_cnt_inc = r_cnt + CNT_W'(1);

    always_comb begin
        n_measuring  = r_measuring;
        n_have_ref   = r_have_ref;
        n_level      = r_level;
        n_last       = r_last;
        n_high       = r_high;
        n_low        = r_low;
        n_cnt        = r_cnt;
        o_push_valid = 1'b0;
        o_push_data.status       = pdpm_pkg::ST_MEASURED;
        if (w_accept) begin
            if (i_req.req_type == pdpm_pkg::REQ_START) begin
                n_measuring = 1'b1;
                n_have_ref  = 1'b0;
                n_level     = i_req.pin_level;
                n_last      = '0;
                n_high      = '0;
                n_low       = '0;
                n_cnt       = '0;
            end else if (r_measuring && i_req.req_type == pdpm_pkg::REQ_TIMEOUT) begin
                n_measuring  = 1'b0;
                o_push_valid = 1'b1;
                o_push_data.status = r_level ? pdpm_pkg::ST_TO_HIGH : pdpm_pkg::ST_TO_LOW;
            end else if (r_measuring && i_req.req_type == pdpm_pkg::REQ_EDGE) begin
                n_level = !r_level;
                n_last  = i_req.stamp;
                if (!r_have_ref) begin
                    n_have_ref = 1'b1;
                end else if (r_last > i_req.stamp) begin
                    // timer wrapped: drop the reference, take it again next edge
                    n_have_ref = 1'b0;
                end else begin
                    if (r_level) begin
                        n_high = w_acc_sat;
                    end else begin
                        n_low = w_acc_sat;
                    end
                    n_cnt = w_cnt_inc;
                    if (w_cnt_inc == CNT_W'(INTERVALS)) begin
                        n_measuring  = 1'b0;
                        o_push_valid = 1'b1;
                    end
                end
            end
        end
        w_per_sum = {1'b0, n_high} + {1'b0, n_low};
        w_per_sat = w_per_sum[SUM_W] ? pdpm_pkg::SUM_MAX : w_per_sum[SUM_W-1:0];
        o_push_data.high_ticks   = n_high;
        o_push_data.low_ticks    = n_low;
        o_push_data.period_ticks = (o_push_data.status == pdpm_pkg::ST_MEASURED) ?
                                   w_per_sat : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measuring <= 1'b0;
            r_have_ref  <= 1'b0;
            r_level     <= 1'b0;
            r_last      <= '0;
            r_high      <= '0;
            r_low       <= '0;
            r_cnt       <= '0;
        end else begin
            r_measuring <= n_measuring;
            r_have_ref  <= n_have_ref;
            r_level     <= n_level;
            r_last      <= n_last;
            r_high      <= n_high;
            r_low       <= n_low;
            r_cnt       <= n_cnt;
        end
    end

endmodule

// File: sv/pdpm_queue.sv
// Two-entry job queue between the front end and the divider back end.
// Uses pdpm_pkg for the job type.
`timescale 1ns / 1ps

module pdpm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  pdpm_pkg::t_job  i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output pdpm_pkg::t_job  o_pop_data
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    pdpm_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != (PTR_W+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// File: sv/pdpm_back.sv
// Back end: takes a job, works out frequency and duty with two bit-serial
// dividers running side by side, and holds the result. Uses pdpm_pkg.
`timescale 1ns / 1ps

module pdpm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pdpm_pkg::CLK_W-1:0]    i_clock_hz,
    input  logic                          i_pop_valid,
    output logic                          o_pop_ready,
    input  pdpm_pkg::t_job                i_pop_data,
    pdpm_res_if.source                    o_res
);
    localparam int SUM_W  = pdpm_pkg::SUM_W;
    localparam int CLK_W  = pdpm_pkg::CLK_W;
    localparam int DUTY_W = pdpm_pkg::DUTY_W;
    localparam int PROD_W = SUM_W + DUTY_W;
    localparam int STEP_W = $clog2(CLK_W);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_LOAD, S_DIV} t_state;

    t_state              r_state;
    pdpm_pkg::t_job      r_job;
    logic [PROD_W-1:0]   r_prod;
    logic [SUM_W-1:0]    r_frem;
    logic [CLK_W-1:0]    r_fq;
    logic [SUM_W-1:0]    r_drem;
    logic [DUTY_W-1:0]   r_dq;
    logic [STEP_W-1:0]   r_step;
    logic                r_valid;

    logic [SUM_W:0]      w_frem_sh;
    logic                w_fge;
    logic [SUM_W:0]      w_frem_nx;
    logic [SUM_W:0]      w_drem_sh;
    logic                w_dge;
    logic [SUM_W:0]      w_drem_nx;
    logic [SUM_W:0]      w_per_ext;

    assign o_pop_ready = (r_state == S_IDLE) && !r_valid;
    assign o_res.valid = r_valid;

    // restoring division steps, one quotient bit per cycle each
    assign w_per_ext = {1'b0, r_job.period_ticks};
    assign w_frem_sh = {r_frem, r_fq[CLK_W-1]};
    assign w_fge     = (w_frem_sh >= w_per_ext);
    assign w_frem_nx = w_fge ? (w_frem_sh - w_per_ext) : w_frem_sh;
    assign w_drem_sh = {r_drem, r_dq[DUTY_W-1]};
    assign w_dge     = (w_drem_sh >= w_per_ext);
    assign w_drem_nx = w_dge ? (w_drem_sh - w_per_ext) : w_drem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && o_res.ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pop_valid && o_pop_ready) begin
                        r_job   <= i_pop_data;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_job.high_ticks * pdpm_pkg::DUTY_FULL;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // high*25600 >> 15 is below the period, so the duty
                    // quotient only needs the low DUTY_W numerator bits
                    r_drem <= r_prod[PROD_W-1:DUTY_W];
                    r_dq   <= r_prod[DUTY_W-1:0];
                    r_frem <= '0;
                    r_fq   <= i_clock_hz;
                    r_step <= '0;
                    if (r_job.period_ticks == '0) begin
                        o_res.status       <= r_job.status;
                        o_res.high_ticks   <= r_job.high_ticks;
                        o_res.low_ticks    <= r_job.low_ticks;
                        o_res.period_ticks <= '0;
                        o_res.freq_hz      <= '0;
                        o_res.duty_pct_q8  <= (r_job.status == pdpm_pkg::ST_TO_HIGH) ?
                                              pdpm_pkg::DUTY_FULL : '0;
                        r_valid            <= 1'b1;
                        r_state            <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_frem <= w_frem_nx[SUM_W-1:0];
                    r_fq   <= {r_fq[CLK_W-2:0], w_fge};
                    if (r_step < STEP_W'(DUTY_W)) begin
                        r_drem <= w_drem_nx[SUM_W-1:0];
                        r_dq   <= {r_dq[DUTY_W-2:0], w_dge};
                    end
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(CLK_W - 1)) begin
                        o_res.status       <= r_job.status;
                        o_res.high_ticks   <= r_job.high_ticks;
                        o_res.low_ticks    <= r_job.low_ticks;
                        o_res.period_ticks <= r_job.period_ticks;
                        o_res.freq_hz      <= {r_fq[CLK_W-2:0], w_fge};
                        o_res.duty_pct_q8  <= r_dq;
                        r_valid            <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/pwm_duty_period_meter.sv
// Top level of the PWM duty and period meter: clock rate register, front
// end, job queue and divider back end. Uses pdpm_pkg and pdpm_ifs.
//
// Usage
//   i_req carries requests: start (clears sums, latches pin level, arms),
//   edge (capture stamp of one pin edge) and timeout. o_res carries one
//   result per finished measurement (after INTERVALS intervals) or per
//   timeout while armed. i_cfg_we/i_cfg_data write the timer rate clock_hz.
//   A request is taken in the cycle it is offered whenever the two-entry
//   job queue has room; while the queue is full every request waits,
//   result or not. A measured result passes the queue, the multiply,
//   the load and 27 divider steps, the last of which also loads the
//   output register; a timeout or zero-period result is loaded by the
//   load step instead. The 27-step bit-serial frequency divider sets the
//   rate: the back end takes no new job until the last result is taken.
//   A stalled receiver holds the result in the output register; the queue
//   then absorbs up to two more results before i_req.ready drops.
//   Synchronous reset disarms the meter, empties the queue, drops any
//   pending result and sets clock_hz to 120000000.
`timescale 1ns / 1ps

module pwm_duty_period_meter #(
    parameter int STAMP_BITS = pdpm_pkg::STAMP_BITS_DEF,
    parameter int INTERVALS  = pdpm_pkg::INTERVALS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pdpm_pkg::CLK_W-1:0]  i_cfg_data,
    pdpm_req_if.sink                    i_req,
    pdpm_res_if.source                  o_res
);
    logic [pdpm_pkg::CLK_W-1:0] r_clock_hz;

    logic           w_push_valid;
    logic           w_push_ready;
    pdpm_pkg::t_job w_push_data;
    logic           w_pop_valid;
    logic           w_pop_ready;
    pdpm_pkg::t_job w_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= pdpm_pkg::CLOCK_RESET;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_data;
        end
    end

    pdpm_front #(
        .STAMP_BITS (STAMP_BITS),
        .INTERVALS  (INTERVALS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    pdpm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    pdpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clock_hz  (r_clock_hz),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_res       (o_res)
    );

endmodule

// File: sv/pdpm_checker.sv
// Port-level checks on the result channel of the PWM duty and period meter,
// bound to the top level. Uses pdpm_pkg.
`timescale 1ns / 1ps

module pdpm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           i_ready,
    input logic [pdpm_pkg::STATUS_W-1:0]  i_status,
    input logic [pdpm_pkg::SUM_W-1:0]     i_high,
    input logic [pdpm_pkg::SUM_W-1:0]     i_low,
    input logic [pdpm_pkg::SUM_W-1:0]     i_period,
    input logic [pdpm_pkg::CLK_W-1:0]     i_freq,
    input logic [pdpm_pkg::DUTY_W-1:0]    i_duty
);
    logic [pdpm_pkg::SUM_W:0] w_sum;
    assign w_sum = {1'b0, i_high} + {1'b0, i_low};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_duty)
                                   && $stable(i_freq)))
        else $error("result request dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == pdpm_pkg::ST_MEASURED) |->
        (w_sum[pdpm_pkg::SUM_W] ? (i_period == pdpm_pkg::SUM_MAX)
                                : (i_period == w_sum[pdpm_pkg::SUM_W-1:0])))
        else $error("period is not the saturated sum of high and low ticks");

    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == pdpm_pkg::ST_TO_HIGH || i_status == pdpm_pkg::ST_TO_LOW))
        |-> (i_period == '0 && i_freq == '0 &&
             i_duty == ((i_status == pdpm_pkg::ST_TO_HIGH) ? pdpm_pkg::DUTY_FULL : '0)))
        else $error("timeout result fields wrong");

    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == pdpm_pkg::ST_MEASURED) |->
        (i_duty <= pdpm_pkg::DUTY_FULL && (i_period != '0 || (i_freq == '0 && i_duty == '0))))
        else $error("measured duty or zero-period result out of range");

endmodule

bind pwm_duty_period_meter pdpm_checker u_pdpm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_status (o_res.status),
    .i_high   (o_res.high_ticks),
    .i_low    (o_res.low_ticks),
    .i_period (o_res.period_ticks),
    .i_freq   (o_res.freq_hz),
    .i_duty   (o_res.duty_pct_q8)
);

// File: sim/pwm_duty_period_meter_tb.sv
// Self-checking testbench for pwm_duty_period_meter: a scoreboard class predicts every
// reading from the accepted requests and checks each result field by field.
// Depends on pdpm_pkg, pdpm_ifs and the RTL of the meter.
`timescale 1ns / 1ps

module pwm_duty_period_meter_tb;

    localparam int STAMP_W = pdpm_pkg::STAMP_BITS_DEF;
    localparam int N_INTERVALS = pdpm_pkg::INTERVALS_DEF;
    localparam logic [pdpm_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [pdpm_pkg::CLK_W-1:0] CLOCK_ALL_ONES = {pdpm_pkg::CLK_W{1'b1}};
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [pdpm_pkg::STATUS_W-1:0] status;
        logic [pdpm_pkg::SUM_W-1:0]    high_ticks;
        logic [pdpm_pkg::SUM_W-1:0]    low_ticks;
        logic [pdpm_pkg::SUM_W-1:0]    period_ticks;
        logic [pdpm_pkg::CLK_W-1:0]    freq_hz;
        logic [pdpm_pkg::DUTY_W-1:0]   duty_pct_q8;
    } t_reading;

    class t_meter_scoreboard;
        logic [pdpm_pkg::CLK_W-1:0] clock_hz;
        bit                         armed;
        bit                         have_ref;
        bit                         level;
        logic [STAMP_W-1:0]         last_stamp;
        logic [pdpm_pkg::SUM_W-1:0] high_sum;
        logic [pdpm_pkg::SUM_W-1:0] low_sum;
        int                         intervals;
        t_reading                   pending_readings[$];
        int                         errors;
        int                         shown;
        int                         n_measured;
        int                         n_timeouts;
        int                         n_wraps;
        int                         n_checked;

        function new();
            clock_hz = pdpm_pkg::CLOCK_RESET;
            armed = 0;
            have_ref = 0;
            level = 0;
            last_stamp = '0;
            high_sum = '0;
            low_sum = '0;
            intervals = 0;
            errors = 0;
            shown = 0;
            n_measured = 0;
            n_timeouts = 0;
            n_wraps = 0;
            n_checked = 0;
        endfunction

        function void set_clock(logic [pdpm_pkg::CLK_W-1:0] v);
            clock_hz = v;
        endfunction

        function logic [pdpm_pkg::SUM_W-1:0] sum_sat(logic [pdpm_pkg::SUM_W-1:0] a,
                                                     logic [pdpm_pkg::SUM_W-1:0] b);
            logic [pdpm_pkg::SUM_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[pdpm_pkg::SUM_W] ? pdpm_pkg::SUM_MAX : s[pdpm_pkg::SUM_W-1:0];
        endfunction

        // Advances the meter state by one accepted request; returns 0 if it was ignored.
        function bit take_request(logic [pdpm_pkg::REQ_W-1:0] req, logic [STAMP_W-1:0] stamp,
                                  logic pin);
            t_reading                   r;
            logic [pdpm_pkg::SUM_W-1:0] period;
            longint unsigned            duty;
            if (req == pdpm_pkg::REQ_START) begin
                armed = 1;
                have_ref = 0;
                level = pin;
                last_stamp = '0;
                high_sum = '0;
                low_sum = '0;
                intervals = 0;
                return 1;
            end
            if (!armed || (req != pdpm_pkg::REQ_EDGE && req != pdpm_pkg::REQ_TIMEOUT))
                return 0;
            if (req == pdpm_pkg::REQ_TIMEOUT) begin
                r.status       = level ? pdpm_pkg::ST_TO_HIGH : pdpm_pkg::ST_TO_LOW;
                r.high_ticks   = high_sum;
                r.low_ticks    = low_sum;
                r.period_ticks = '0;
                r.freq_hz      = '0;
                r.duty_pct_q8  = level ? pdpm_pkg::DUTY_FULL : '0;
                pending_readings.push_back(r);
                armed = 0;
                n_timeouts++;
                return 1;
            end
            if (!have_ref) begin
                have_ref = 1;
                last_stamp = stamp;
            end else if (last_stamp > stamp) begin
                // timer wrapped: drop the reference, take it again on the next edge
                have_ref = 0;
                last_stamp = stamp;
                n_wraps++;
            end else begin
                if (level)
                    high_sum = sum_sat(high_sum, pdpm_pkg::SUM_W'(stamp - last_stamp));
                else
                    low_sum = sum_sat(low_sum, pdpm_pkg::SUM_W'(stamp - last_stamp));
                last_stamp = stamp;
                intervals++;
                if (intervals >= N_INTERVALS) begin
                    period = sum_sat(high_sum, low_sum);
                    r.status       = pdpm_pkg::ST_MEASURED;
                    r.high_ticks   = high_sum;
                    r.low_ticks    = low_sum;
                    r.period_ticks = period;
                    r.freq_hz      = '0;
                    r.duty_pct_q8  = '0;
                    if (period != 0) begin
                        r.freq_hz = pdpm_pkg::CLK_W'(longint'(clock_hz) / longint'(period));
                        duty = (longint'(high_sum) * longint'(pdpm_pkg::DUTY_FULL))
                               / longint'(period);
                        r.duty_pct_q8 = (duty > pdpm_pkg::DUTY_FULL) ?
                                        pdpm_pkg::DUTY_FULL : pdpm_pkg::DUTY_W'(duty);
                    end
                    pending_readings.push_back(r);
                    armed = 0;
                    n_measured++;
                end
            end
            level = ~level;
            return 1;
        endfunction

        function void report(string field, longint unsigned e, longint unsigned a);
            errors++;
            if (shown < 100)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
            shown++;
        endfunction

        function void match_result(t_reading got);
            t_reading e;
            if (pending_readings.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            e = pending_readings.pop_front();
            n_checked++;
            if (got.status !== e.status)
                report("status", e.status, got.status);
            if (got.high_ticks !== e.high_ticks)
                report("high_ticks", e.high_ticks, got.high_ticks);
            if (got.low_ticks !== e.low_ticks)
                report("low_ticks", e.low_ticks, got.low_ticks);
            if (got.period_ticks !== e.period_ticks)
                report("period_ticks", e.period_ticks, got.period_ticks);
            if (got.freq_hz !== e.freq_hz)
                report("freq_hz", e.freq_hz, got.freq_hz);
            if (got.duty_pct_q8 !== e.duty_pct_q8)
                report("duty_pct_q8", e.duty_pct_q8, got.duty_pct_q8);
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [pdpm_pkg::CLK_W-1:0]   i_cfg_data;

    pdpm_req_if #(.STAMP_BITS(STAMP_W)) req_if ();
    pdpm_res_if                         res_if ();

    pwm_duty_period_meter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    t_meter_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold_req;
    int stalled_cycles;
    int items_counted;
    int n_clock_settings;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_request(input logic [pdpm_pkg::REQ_W-1:0] req,
                                input logic [STAMP_W-1:0] stamp, input logic pin);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= req;
        req_if.stamp     <= stamp;
        req_if.pin_level <= pin;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        if (sb.take_request(req, stamp, pin))
            items_counted++;
    endtask

    // Clock rate changes only with requests held off and every reading collected.
    task automatic write_clock(input logic [pdpm_pkg::CLK_W-1:0] v);
        req_if.valid <= 1'b0;
        while (sb.pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_clock(v);
        i_cfg_we <= 1'b0;
        n_clock_settings++;
    endtask

    function automatic logic [STAMP_W-1:0] pick_delta();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 55)
            return STAMP_W'($urandom_range(1, 2000));
        if (r < 85)
            return STAMP_W'($urandom_range(1, 1 << 20));
        return STAMP_W'($urandom);
    endfunction

    // Mostly complete measurements with random timing; the rest are timeouts,
    // restarts, wraps and stray requests.
    task automatic run_random(input int target);
        int               base;
        int               k;
        int unsigned      r;
        logic [STAMP_W-1:0] t;
        base = items_counted;
        while (items_counted - base < target) begin
            if ($urandom_range(99) < 80) begin
                send_request(pdpm_pkg::REQ_START, STAMP_W'($urandom), 1'($urandom_range(1)));
                t = $urandom_range(1) ? STAMP_W'($urandom) : STAMP_W'($urandom_range(4095));
                send_request(pdpm_pkg::REQ_EDGE, t, 1'($urandom_range(1)));
                k = 0;
                while (sb.armed && k < 8) begin
                    r = $urandom_range(99);
                    if (r < 7) begin
                        send_request(pdpm_pkg::REQ_TIMEOUT, STAMP_W'($urandom),
                                     1'($urandom_range(1)));
                    end else if (r < 11) begin
                        send_request(pdpm_pkg::REQ_START, STAMP_W'($urandom),
                                     1'($urandom_range(1)));
                    end else begin
                        t = t + pick_delta();
                        send_request(pdpm_pkg::REQ_EDGE, t, 1'($urandom_range(1)));
                    end
                    k++;
                end
            end else begin
                send_request(pdpm_pkg::REQ_W'($urandom_range(3)), STAMP_W'($urandom),
                             1'($urandom_range(1)));
            end
        end
    endtask

    initial begin : result_sink
        t_reading got;
        int       hold_left;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got.status       = res_if.status;
                got.high_ticks   = res_if.high_ticks;
                got.low_ticks    = res_if.low_ticks;
                got.period_ticks = res_if.period_ticks;
                got.freq_hz      = res_if.freq_hz;
                got.duty_pct_q8  = res_if.duty_pct_q8;
                sb.match_result(got);
            end
            if (hold_left > 0 && req_if.valid && !req_if.ready)
                stalled_cycles++;
            if (rx_hold_req) begin
                hold_left = LONG_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        sb = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        req_if.valid     = 1'b0;
        req_if.req_type  = pdpm_pkg::REQ_START;
        req_if.stamp     = '0;
        req_if.pin_level = 1'b0;
        res_if.ready     = 1'b0;
        tx_idle_pct      = 23;
        rx_idle_pct      = 67;
        rx_hold_req      = 1'b0;
        stalled_cycles   = 0;
        items_counted    = 0;
        n_clock_settings = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray requests while idle, full-scale stamps, zero period,
        // both timeouts, counter wrap and restart while armed
        send_request(pdpm_pkg::REQ_EDGE, {STAMP_W{1'b1}}, 1'b1);
        send_request(pdpm_pkg::REQ_TIMEOUT, '0, 1'b0);
        send_request(REQ_UNUSED, 24'hABCDEF, 1'b1);
        send_request(pdpm_pkg::REQ_START, '0, 1'b1);
        send_request(pdpm_pkg::REQ_EDGE, '0, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, {STAMP_W{1'b1}}, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, {STAMP_W{1'b1}}, 1'b1);
        send_request(pdpm_pkg::REQ_START, '0, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd100, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd100, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd100, 1'b0);
        send_request(pdpm_pkg::REQ_START, '0, 1'b1);
        send_request(pdpm_pkg::REQ_TIMEOUT, '0, 1'b0);
        send_request(pdpm_pkg::REQ_START, '0, 1'b0);
        send_request(pdpm_pkg::REQ_TIMEOUT, '0, 1'b0);
        send_request(pdpm_pkg::REQ_START, '0, 1'b1);
        send_request(pdpm_pkg::REQ_EDGE, 24'd1000, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd500, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd600, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd700, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd1000, 1'b0);
        send_request(pdpm_pkg::REQ_START, '0, 1'b1);
        send_request(pdpm_pkg::REQ_EDGE, 24'd10, 1'b0);
        send_request(pdpm_pkg::REQ_START, '0, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd20, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd30, 1'b0);
        send_request(pdpm_pkg::REQ_EDGE, 24'd31, 1'b0);

        write_clock('0);
        run_random(150);
        write_clock(pdpm_pkg::CLK_W'(1));
        run_random(150);

        tx_idle_pct = 67;
        rx_idle_pct = 23;
        write_clock(CLOCK_ALL_ONES);
        run_random(300);
        write_clock(pdpm_pkg::CLOCK_RESET);
        run_random(300);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_clock(pdpm_pkg::CLK_W'($urandom_range(1, 120000000)));
        rx_hold_req = 1'b1;
        run_random(450);
        write_clock(pdpm_pkg::CLK_W'($urandom_range(1, 120000000)));
        run_random(450);

        req_if.valid <= 1'b0;
        while (sb.pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending_readings.size() != 0) begin
            sb.errors += sb.pending_readings.size();
            $display("%0t ns: %0d readings never arrived", $time, sb.pending_readings.size());
        end

        $display("Covered %0d requests over %0d clock rate settings: %0d measured,",
                 items_counted, n_clock_settings, sb.n_measured);
        $display("%0d timeouts, %0d timer wraps, %0d results checked, %0d stalled cycles.",
                 sb.n_timeouts, sb.n_wraps, sb.n_checked, stalled_cycles);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/pdpm_pkg.sv
sv/pdpm_ifs.sv
sv/pdpm_front.sv
sv/pdpm_queue.sv
sv/pdpm_back.sv
sv/pwm_duty_period_meter.sv
sv/pdpm_checker.sv
sim/pwm_duty_period_meter_tb.sv
